FILE: src/mfa_pkg.sv
// Shared constants and codes for the mixed fraction ALU.
package mfa_pkg;

  localparam int unsigned RES_W     = 48;
  localparam int unsigned RES_BOT_W = 47;

  localparam logic [RES_W-1:0] LIM47 = 48'h7FFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    ACT_ADD = 2'd0,
    ACT_SUB = 2'd1,
    ACT_MUL = 2'd2,
    ACT_DIV = 2'd3
  } action_e;

  localparam logic [1:0] ERR_OK   = 2'd0;
  localparam logic [1:0] ERR_ZERO = 2'd1;
  localparam logic [1:0] ERR_OVF  = 2'd2;

endpackage

FILE: src/mfa_if.sv
// Handshake channels carrying operand and result words.
interface mfa_in_if #(parameter int unsigned OPERAND_BITS = 16);
  logic                           valid;
  logic                           ready;
  logic [1:0]                     action;
  logic signed [OPERAND_BITS-1:0] a_whole;
  logic [OPERAND_BITS-2:0]        a_top;
  logic [OPERAND_BITS-2:0]        a_bottom;
  logic signed [OPERAND_BITS-1:0] b_whole;
  logic [OPERAND_BITS-2:0]        b_top;
  logic [OPERAND_BITS-2:0]        b_bottom;

  modport source (output valid, action, a_whole, a_top, a_bottom, b_whole, b_top, b_bottom,
                  input ready);
  modport sink   (input valid, action, a_whole, a_top, a_bottom, b_whole, b_top, b_bottom,
                  output ready);
endinterface

interface mfa_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [mfa_pkg::RES_W-1:0]    res_whole;
  logic signed [mfa_pkg::RES_W-1:0]    res_top;
  logic [mfa_pkg::RES_BOT_W-1:0]       res_bottom;
  logic [1:0]                          error_code;

  modport source (output valid, res_whole, res_top, res_bottom, error_code, input ready);
  modport sink   (input valid, res_whole, res_top, res_bottom, error_code, output ready);
endinterface

FILE: src/mixed_fraction_alu_top.sv
// Mixed fraction ALU: exact add, subtract, multiply, divide with GCD reduction.
//
// The operand channel in_i takes one word holding the operation and two mixed
// fractions; the result channel out_o returns one word per operand word with the
// truncated integer part, the reduced signed remainder, the reduced denominator
// and an error code. Both channels complete a transfer when valid and ready are
// high at a rising clock edge.
// One shift-add multiplier and one restoring divider, each retiring one bit per
// cycle, do all the work under a small sequencer.
// in_i.ready is high only while the sequencer is idle. A finished result moves
// to an output register; if the receiver stalls, the next word is still taken
// and the new result waits inside until the output register frees up.
// Reset clears the sequencer and the output valid flag; no result is pending.
module mixed_fraction_alu_top #(
  parameter int unsigned OPERAND_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mfa_in_if.sink    in_i,
  mfa_out_if.source out_o
);
  import mfa_pkg::*;

  localparam int unsigned W  = OPERAND_BITS;
  localparam int unsigned FW = W - 1;
  localparam int unsigned MW = 2 * W;
  localparam int unsigned NW = 4 * W;
  localparam int unsigned XW = (NW > RES_W) ? NW : RES_W;
  localparam int unsigned CW = $clog2(NW + 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SEQ  = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  typedef enum logic [3:0] {
    PH_WA, PH_WB, PH_T1, PH_T2, PH_DEN, PH_CHK, PH_GCD, PH_RN, PH_RD, PH_Q
  } phase_e;

  typedef struct packed {
    logic          neg;
    logic [NW-1:0] mag;
  } snum_t;

  function automatic snum_t s_add(input logic xn, input logic [NW-1:0] xm,
                                  input logic yn, input logic [NW-1:0] ym);
    snum_t r;
    if (xn == yn) begin
      r.mag = xm + ym;
      r.neg = xn;
    end else if (xm >= ym) begin
      r.mag = xm - ym;
      r.neg = xn;
    end else begin
      r.mag = ym - xm;
      r.neg = yn;
    end
    if (r.mag == '0) r.neg = 1'b0;
    return r;
  endfunction

  state_e state_q, state_d;
  phase_e phase_q, phase_d;

  logic [1:0]    act_q, act_d;
  logic [W-1:0]  wa_q, wa_d, wb_q, wb_d;
  logic [FW-1:0] ta_q, ta_d, da_q, da_d, tb_q, tb_d, db_q, db_d;
  logic          na_neg_q, na_neg_d, nb_neg_q, nb_neg_d, num_neg_q, num_neg_d;
  logic [MW-1:0] na_q, na_d, nb_q, nb_d;
  logic [NW-1:0] num_q, num_d, den_q, den_d, ga_q, ga_d, gb_q, gb_d;

  logic [NW-1:0] mx_q, mx_d, acc_q, acc_d;
  logic [MW-1:0] my_q, my_d;
  logic [NW-1:0] dn_q, dn_d, dd_q, dd_d, rr_q, rr_d, qq_q, qq_d;
  logic [CW-1:0] cnt_q, cnt_d;

  logic [RES_W-1:0]     pw_q, pw_d, pt_q, pt_d;
  logic [RES_BOT_W-1:0] pb_q, pb_d;
  logic [1:0]           pe_q, pe_d;

  logic                 ov_q, ov_d;
  logic [RES_W-1:0]     ow_q, ow_d, ot_q, ot_d;
  logic [RES_BOT_W-1:0] ob_q, ob_d;
  logic [1:0]           oe_q, oe_d;

  logic [W-1:0]  wa_abs, wb_abs;
  logic [NW:0]   trial;
  snum_t         sa;
  logic [XW-1:0] q_ext, r_ext, d_ext, q_lim;

  assign wa_abs = wa_q[W-1] ? (~wa_q + W'(1)) : wa_q;
  assign wb_abs = wb_q[W-1] ? (~wb_q + W'(1)) : wb_q;
  assign trial  = {rr_q, dn_q[NW-1]};
  assign q_ext  = XW'(qq_q);
  assign r_ext  = XW'(rr_q);
  assign d_ext  = XW'(den_q);
  assign q_lim  = num_neg_q ? XW'(LIM47) + XW'(1) : XW'(LIM47);

  assign in_i.ready       = (state_q == ST_IDLE);
  assign out_o.valid      = ov_q;
  assign out_o.res_whole  = ow_q;
  assign out_o.res_top    = ot_q;
  assign out_o.res_bottom = ob_q;
  assign out_o.error_code = oe_q;

  always_comb begin
    state_d = state_q;  phase_d = phase_q;
    act_d = act_q;  wa_d = wa_q;  wb_d = wb_q;
    ta_d = ta_q;  da_d = da_q;  tb_d = tb_q;  db_d = db_q;
    na_neg_d = na_neg_q;  nb_neg_d = nb_neg_q;  num_neg_d = num_neg_q;
    na_d = na_q;  nb_d = nb_q;  num_d = num_q;  den_d = den_q;  ga_d = ga_q;  gb_d = gb_q;
    mx_d = mx_q;  my_d = my_q;  acc_d = acc_q;
    dn_d = dn_q;  dd_d = dd_q;  rr_d = rr_q;  qq_d = qq_q;  cnt_d = cnt_q;
    pw_d = pw_q;  pt_d = pt_q;  pb_d = pb_q;  pe_d = pe_q;
    ov_d = ov_q;  ow_d = ow_q;  ot_d = ot_q;  ob_d = ob_q;  oe_d = oe_q;
    sa = '0;

    if (ov_q && out_o.ready) ov_d = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          act_d = in_i.action;
          wa_d = in_i.a_whole;  ta_d = in_i.a_top;  da_d = in_i.a_bottom;
          wb_d = in_i.b_whole;  tb_d = in_i.b_top;  db_d = in_i.b_bottom;
          if (in_i.a_bottom == '0 || in_i.b_bottom == '0) begin
            pw_d = '0;  pt_d = '0;  pb_d = RES_BOT_W'(1);  pe_d = ERR_ZERO;
            state_d = ST_DONE;
          end else begin
            phase_d = PH_WA;
            state_d = ST_SEQ;
          end
        end
      end

      ST_SEQ: begin
        // Launch the next multiply or divide of the sequence, or move on without one.
        cnt_d = '0;
        acc_d = '0;
        rr_d  = '0;
        qq_d  = '0;
        state_d = ST_MUL;
        case (phase_q)
          PH_WA: begin mx_d = NW'(wa_abs); my_d = MW'(da_q); end
          PH_WB: begin mx_d = NW'(wb_abs); my_d = MW'(db_q); end
          PH_T1: begin
            mx_d = NW'(na_q);
            my_d = (act_q == ACT_MUL) ? nb_q : MW'(db_q);
          end
          PH_T2: begin mx_d = NW'(nb_q); my_d = MW'(da_q); end
          PH_DEN: begin mx_d = NW'(da_q); my_d = MW'(db_q); end
          PH_CHK: begin
            if (num_q == '0) begin
              pw_d = '0;  pt_d = '0;  pb_d = RES_BOT_W'(1);  pe_d = ERR_OK;
              state_d = ST_DONE;
            end else begin
              ga_d = num_q;  gb_d = den_q;
              phase_d = PH_GCD;
              state_d = ST_SEQ;
            end
          end
          PH_GCD: begin
            if (gb_q == '0) begin
              phase_d = PH_RN;
              state_d = ST_SEQ;
            end else begin
              dn_d = ga_q;  dd_d = gb_q;  state_d = ST_DIV;
            end
          end
          PH_RN: begin dn_d = num_q; dd_d = ga_q;  state_d = ST_DIV; end
          PH_RD: begin dn_d = den_q; dd_d = ga_q;  state_d = ST_DIV; end
          PH_Q:  begin dn_d = num_q; dd_d = den_q; state_d = ST_DIV; end
          default: state_d = ST_IDLE;
        endcase
      end

      ST_MUL: begin
        if (cnt_q != CW'(MW)) begin
          if (my_q[0]) acc_d = acc_q + mx_q;
          mx_d  = mx_q << 1;
          my_d  = my_q >> 1;
          cnt_d = cnt_q + CW'(1);
        end else begin
          state_d = ST_SEQ;
          case (phase_q)
            PH_WA: begin
              sa = s_add(wa_q[W-1], acc_q, 1'b0, NW'(ta_q));
              na_neg_d = sa.neg;  na_d = sa.mag[MW-1:0];
              phase_d = PH_WB;
            end
            PH_WB: begin
              sa = s_add(wb_q[W-1], acc_q, 1'b0, NW'(tb_q));
              nb_neg_d = sa.neg;  nb_d = sa.mag[MW-1:0];
              phase_d = PH_T1;
              if (act_q == ACT_DIV && sa.mag == '0) begin
                pw_d = '0;  pt_d = '0;  pb_d = RES_BOT_W'(1);  pe_d = ERR_ZERO;
                state_d = ST_DONE;
              end
            end
            PH_T1: begin
              num_d = acc_q;
              num_neg_d = (act_q == ACT_MUL || act_q == ACT_DIV) ? (na_neg_q ^ nb_neg_q)
                                                                   : na_neg_q;
              phase_d = (act_q == ACT_MUL) ? PH_DEN : PH_T2;
            end
            PH_T2: begin
              if (act_q == ACT_DIV) begin
                den_d = acc_q;
                phase_d = PH_CHK;
              end else begin
                sa = s_add(num_neg_q, num_q, nb_neg_q ^ (act_q == ACT_SUB), acc_q);
                num_neg_d = sa.neg;  num_d = sa.mag;
                phase_d = PH_DEN;
              end
            end
            default: begin
              den_d = acc_q;
              phase_d = PH_CHK;
            end
          endcase
        end
      end

      ST_DIV: begin
        if (cnt_q != CW'(NW)) begin
          // Restoring division, one quotient bit per cycle.
          if (trial >= {1'b0, dd_q}) begin
            rr_d = NW'(trial - {1'b0, dd_q});
            qq_d = {qq_q[NW-2:0], 1'b1};
          end else begin
            rr_d = trial[NW-1:0];
            qq_d = {qq_q[NW-2:0], 1'b0};
          end
          dn_d  = dn_q << 1;
          cnt_d = cnt_q + CW'(1);
        end else begin
          state_d = ST_SEQ;
          case (phase_q)
            PH_GCD: begin ga_d = gb_q; gb_d = rr_q; end
            PH_RN:  begin num_d = qq_q; phase_d = PH_RD; end
            PH_RD:  begin den_d = qq_q; phase_d = PH_Q; end
            default: begin
              state_d = ST_DONE;
              if (d_ext > XW'(LIM47) || q_ext > q_lim) begin
                pw_d = '0;  pt_d = '0;  pb_d = RES_BOT_W'(1);  pe_d = ERR_OVF;
              end else begin
                pw_d = num_neg_q ? (~q_ext[RES_W-1:0] + RES_W'(1)) : q_ext[RES_W-1:0];
                pt_d = num_neg_q ? (~r_ext[RES_W-1:0] + RES_W'(1)) : r_ext[RES_W-1:0];
                pb_d = d_ext[RES_BOT_W-1:0];
                pe_d = ERR_OK;
              end
            end
          endcase
        end
      end

      ST_DONE: begin
        if (!ov_q || out_o.ready) begin
          ov_d = 1'b1;
          ow_d = pw_q;  ot_d = pt_q;  ob_d = pb_q;  oe_d = pe_q;
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_WA;
      ov_q    <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      ov_q    <= ov_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q <= act_d;  wa_q <= wa_d;  wb_q <= wb_d;
    ta_q <= ta_d;  da_q <= da_d;  tb_q <= tb_d;  db_q <= db_d;
    na_neg_q <= na_neg_d;  nb_neg_q <= nb_neg_d;  num_neg_q <= num_neg_d;
    na_q <= na_d;  nb_q <= nb_d;  num_q <= num_d;  den_q <= den_d;
    ga_q <= ga_d;  gb_q <= gb_d;
    mx_q <= mx_d;  my_q <= my_d;  acc_q <= acc_d;
    dn_q <= dn_d;  dd_q <= dd_d;  rr_q <= rr_d;  qq_q <= qq_d;
    pw_q <= pw_d;  pt_q <= pt_d;  pb_q <= pb_d;  pe_q <= pe_d;
    ow_q <= ow_d;  ot_q <= ot_d;  ob_q <= ob_d;  oe_q <= oe_d;
  end

endmodule

FILE: tb/tb_mixed_fraction_alu_top.sv
// Self-checking testbench for the mixed fraction ALU: directed, random and stall tests.
`timescale 1ns / 100ps

module tb_mixed_fraction_alu_top;
  import mfa_pkg::*;

  localparam int unsigned OPERAND_BITS = 16;
  localparam int unsigned FRAC_W       = OPERAND_BITS - 1;
  localparam int unsigned QUIET_LIMIT  = 20000;
  localparam int unsigned DRAIN_CYCLES = 6000;
  localparam int unsigned HOLD_CYCLES  = 3000;

  typedef struct packed {
    logic signed [RES_W-1:0] whole;
    logic signed [RES_W-1:0] top;
    logic [RES_BOT_W-1:0]    bottom;
    logic [1:0]              err;
  } frac_res_t;

  logic clk_i;
  logic rst_ni;

  mfa_in_if #(.OPERAND_BITS(OPERAND_BITS)) in_if ();
  mfa_out_if out_if ();

  mixed_fraction_alu_top #(.OPERAND_BITS(OPERAND_BITS)) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  frac_res_t   pending_q[$];
  int unsigned n_sent        = 0;
  int unsigned n_checked     = 0;
  int unsigned n_errors      = 0;
  int unsigned n_flagged     = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;
  bit          idle_on;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Exact rational result of one operand word, reduced and in mixed form.
  function automatic frac_res_t fraction_result(action_e op,
      logic signed [OPERAND_BITS-1:0] aw, logic [OPERAND_BITS-2:0] at,
      logic [OPERAND_BITS-2:0] ab, logic signed [OPERAND_BITS-1:0] bw,
      logic [OPERAND_BITS-2:0] bt, logic [OPERAND_BITS-2:0] bb);
    frac_res_t   res;
    longint      na, nb, num, den;
    longint      mag, d, g, x, y, t, q, r;
    bit          neg;
    res.whole  = '0;
    res.top    = '0;
    res.bottom = RES_BOT_W'(1);
    res.err    = ERR_OK;
    if (ab == 0 || bb == 0) begin
      res.err = ERR_ZERO;
      return res;
    end
    na = longint'(aw) * longint'(ab) + longint'(at);
    nb = longint'(bw) * longint'(bb) + longint'(bt);
    case (op)
      ACT_ADD: begin
        num = na * longint'(bb) + nb * longint'(ab);
        den = longint'(ab) * longint'(bb);
      end
      ACT_SUB: begin
        num = na * longint'(bb) - nb * longint'(ab);
        den = longint'(ab) * longint'(bb);
      end
      ACT_MUL: begin
        num = na * nb;
        den = longint'(ab) * longint'(bb);
      end
      default: begin
        if (nb == 0) begin
          res.err = ERR_ZERO;
          return res;
        end
        num = na * longint'(bb);
        den = nb * longint'(ab);
        if (den < 0) begin
          num = -num;
          den = -den;
        end
      end
    endcase
    if (num == 0) return res;
    neg = num < 0;
    mag = neg ? -num : num;
    x = mag;
    y = den;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    g = x;
    mag = mag / g;
    d = den / g;
    q = mag / d;
    r = mag % d;
    if (d > longint'(LIM47) || q > (neg ? longint'(LIM47) + 1 : longint'(LIM47))) begin
      res.err = ERR_OVF;
      return res;
    end
    res.whole  = neg ? -q[RES_W-1:0] : q[RES_W-1:0];
    res.top    = neg ? -r[RES_W-1:0] : r[RES_W-1:0];
    res.bottom = d[RES_BOT_W-1:0];
    return res;
  endfunction

  task automatic send_word(action_e op, logic signed [OPERAND_BITS-1:0] aw,
      logic [OPERAND_BITS-2:0] at, logic [OPERAND_BITS-2:0] ab,
      logic signed [OPERAND_BITS-1:0] bw, logic [OPERAND_BITS-2:0] bt,
      logic [OPERAND_BITS-2:0] bb);
    int unsigned gap;
    if (idle_on && $urandom_range(99) < 12) begin
      gap = $urandom_range(1, 6);
      @(negedge clk_i);
      in_if.valid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_if.valid    = 1'b1;
    in_if.action   = op;
    in_if.a_whole  = aw;
    in_if.a_top    = at;
    in_if.a_bottom = ab;
    in_if.b_whole  = bw;
    in_if.b_top    = bt;
    in_if.b_bottom = bb;
    do @(posedge clk_i); while (!in_if.ready);
    pending_q.push_back(fraction_result(op, aw, at, ab, bw, bt, bb));
    n_sent++;
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    in_if.valid = 1'b0;
  endtask

  task automatic wait_drained();
    stop_sending();
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  // Denominators lean to small values so the Euclid loop stays short most of the time.
  function automatic logic [OPERAND_BITS-2:0] pick_bottom();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 3) return '0;
    if (sel < 55) return FRAC_W'($urandom_range(1, 12));
    if (sel < 80) return FRAC_W'($urandom_range(1, 300));
    return FRAC_W'($urandom_range(1, 32767));
  endfunction

  function automatic logic signed [OPERAND_BITS-1:0] pick_whole();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 10) return '0;
    if (sel < 60) return OPERAND_BITS'($urandom_range(0, 40) - 20);
    return OPERAND_BITS'($urandom());
  endfunction

  function automatic logic [OPERAND_BITS-2:0] pick_top(logic [OPERAND_BITS-2:0] bottom);
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 15) return '0;
    if (sel < 80 && bottom != 0) return FRAC_W'($urandom_range(0, bottom - 1));
    return FRAC_W'($urandom());
  endfunction

  task automatic send_random_word();
    logic [OPERAND_BITS-2:0] ab, bb;
    logic signed [OPERAND_BITS-1:0] bw;
    logic [OPERAND_BITS-2:0] bt;
    ab = pick_bottom();
    bb = pick_bottom();
    bw = pick_whole();
    bt = pick_top(bb);
    // Now and then a divisor of exactly zero.
    if ($urandom_range(99) < 4) begin
      bw = '0;
      bt = '0;
    end
    send_word(action_e'(2'($urandom_range(3))), pick_whole(), pick_top(ab), ab, bw, bt, bb);
  endtask

  task automatic test_directed();
    send_word(ACT_ADD, 16'sd1, 15'd1, 15'd2, 16'sd2, 15'd1, 15'd3);
    send_word(ACT_SUB, 16'sd1, 15'd1, 15'd2, 16'sd2, 15'd1, 15'd3);
    send_word(ACT_MUL, 16'sd1, 15'd1, 15'd2, 16'sd2, 15'd1, 15'd3);
    send_word(ACT_DIV, 16'sd1, 15'd1, 15'd2, 16'sd2, 15'd1, 15'd3);
    // A negative whole with a positive top lies closer to zero.
    send_word(ACT_ADD, -16'sd1, 15'd1, 15'd2, 16'sd0, 15'd0, 15'd1);
    send_word(ACT_ADD, 16'sd1, 15'd0, 15'd0, 16'sd1, 15'd0, 15'd1);
    send_word(ACT_MUL, 16'sd1, 15'd0, 15'd1, 16'sd1, 15'd0, 15'd0);
    send_word(ACT_DIV, 16'sd5, 15'd1, 15'd3, 16'sd0, 15'd0, 15'd7);
    send_word(ACT_DIV, 16'sd3, 15'd0, 15'd1, -16'sd1, 15'd1, 15'd1);
    send_word(ACT_SUB, 16'sd2, 15'd1, 15'd4, 16'sd2, 15'd1, 15'd4);
    send_word(ACT_MUL, 16'sd0, 15'd0, 15'd9, -16'sd7, 15'd3, 15'd5);
    // Unreduced and improper operands are taken as given.
    send_word(ACT_ADD, 16'sd0, 15'd4, 15'd8, 16'sd0, 15'd6, 15'd3);
    send_word(ACT_SUB, 16'sd0, 15'd7, 15'd7, 16'sd0, 15'd32767, 15'd2);
    send_word(ACT_MUL, -16'sd32768, 15'd32767, 15'd32767, -16'sd32768, 15'd32767, 15'd32767);
    send_word(ACT_MUL, 16'sd32767, 15'd32767, 15'd1, 16'sd32767, 15'd32767, 15'd1);
    send_word(ACT_DIV, -16'sd32768, 15'd0, 15'd32767, 16'sd0, 15'd1, 15'd32767);
    send_word(ACT_DIV, 16'sd32767, 15'd32767, 15'd1, 16'sd0, 15'd1, 15'd32767);
    send_word(ACT_ADD, -16'sd32768, 15'd0, 15'd1, -16'sd32768, 15'd0, 15'd1);
    send_word(ACT_SUB, 16'sd32767, 15'd32766, 15'd32767, -16'sd32768, 15'd1, 15'd32766);
    send_word(ACT_DIV, -16'sd3, 15'd2, 15'd5, -16'sd2, 15'd1, 15'd3);
    wait_drained();
  endtask

  task automatic test_random(int unsigned count);
    repeat (count) send_random_word();
  endtask

  task automatic test_output_stall();
    wait_drained();
    // The receiver stops taking results while words keep coming, so the block backs up.
    hold_requests++;
    repeat (8) send_random_word();
    wait_drained();
    // Sender pause with nothing left in flight.
    repeat (50) @(negedge clk_i);
  endtask

  // Receiver: random stalls, or a counted hold-off when one is requested.
  always @(negedge clk_i) begin
    if (hold_served != hold_requests) begin
      hold_served  <= hold_requests;
      hold_left    <= HOLD_CYCLES - 1;
      out_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else begin
      out_if.ready <= !(idle_on && $urandom_range(99) < 12);
    end
  end

  always @(posedge clk_i) begin
    frac_res_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_q.size() == 0) begin
        $display("%0t: result word with nothing expected: got %0d %0d/%0d err %0d", $time,
                 out_if.res_whole, out_if.res_top, out_if.res_bottom, out_if.error_code);
        n_errors++;
      end else begin
        want = pending_q.pop_front();
        if (out_if.res_whole !== want.whole || out_if.res_top !== want.top ||
            out_if.res_bottom !== want.bottom || out_if.error_code !== want.err) begin
          $display("%0t: mismatch: expected %0d %0d/%0d err %0d, got %0d %0d/%0d err %0d",
                   $time, want.whole, want.top, want.bottom, want.err, out_if.res_whole,
                   out_if.res_top, out_if.res_bottom, out_if.error_code);
          n_errors++;
        end
        if (want.err != ERR_OK) n_flagged++;
        n_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding", $time,
               QUIET_LIMIT, pending_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    idle_on        = 1'b1;
    rst_ni         = 1'b0;
    in_if.valid    = 1'b0;
    in_if.action   = ACT_ADD;
    in_if.a_whole  = '0;
    in_if.a_top    = '0;
    in_if.a_bottom = '0;
    in_if.b_whole  = '0;
    in_if.b_top    = '0;
    in_if.b_bottom = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_random(400);
    test_output_stall();
    // A stretch with both sides always willing.
    idle_on = 1'b0;
    test_random(150);
    idle_on = 1'b1;
    test_random(330);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d operand words, checked %0d results (%0d with an error code),", n_sent,
             n_checked, n_flagged);
    $display("covering all four operations, zero operands, stalls and a long output hold.");
    if (n_errors == 0 && pending_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/mfa_pkg.sv
src/mfa_if.sv
src/mixed_fraction_alu_top.sv
tb/tb_mixed_fraction_alu_top.sv
